[hw/rtl/rational_arithmetic_unit_defines.svh]
// Assertion macros shared by the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rau assertion failed");
`define RAU_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rau assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rstn, ante, cons)
`define RAU_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/rau_pkg.sv]
package rau_pkg;

    localparam int WORD_BITS = 32;
    localparam int IN_BITS   = 128;
    localparam int OUT_BITS  = 72;

    typedef enum logic [3:0] {
        KIND_MAKE = 4'd0,
        KIND_ADD  = 4'd1,
        KIND_SUB  = 4'd2,
        KIND_MUL  = 4'd3,
        KIND_DIV  = 4'd4,
        KIND_EQ   = 4'd5,
        KIND_NE   = 4'd6,
        KIND_LE   = 4'd7,
        KIND_GE   = 4'd8,
        KIND_LT   = 4'd9,
        KIND_GT   = 4'd10
    } kind_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_ZERO_DEN = 2'd1,
        STS_OVERFLOW = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_COMBINE,
        OP_PREP,
        OP_GCD_STEP,
        OP_SCALE,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_WRITE
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL0,
        ST_MUL1,
        ST_MUL2,
        ST_COMBINE,
        ST_PREP,
        ST_GCD,
        ST_SCALE,
        ST_DIVLD_N,
        ST_DIV_N,
        ST_DIVLD_D,
        ST_DIV_D,
        ST_WRITE
    } state_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] idx;
        logic       sel;
    } cmd_t;

    typedef struct packed {
        logic early;
        logic is_cmp;
        logic gcd_done;
        logic div_last;
    } sts_t;

endpackage

[hw/rtl/rau_datapath.sv]
module rau_datapath
    import rau_pkg::*;
(
    input  logic                aclk,
    input  cmd_t                cmd,
    input  logic [3:0]          in_kind,
    input  logic [IN_BITS-1:0]  in_data,
    output sts_t                sts,
    output logic [OUT_BITS-1:0] out_data
);

    localparam logic [64:0] LIM = 65'(1) << (WORD_BITS - 1);

    function automatic logic [31:0] abs32(input logic [31:0] v);
        return v[31] ? (~v + 32'd1) : v;
    endfunction

    function automatic logic [65:0] to_signed(input logic neg, input logic [63:0] mag);
        return neg ? (~{2'b00, mag} + 66'd1) : {2'b00, mag};
    endfunction

    logic [31:0] an_w, ad_w, bn_w, bd_w;
    logic [31:0] an_abs, ad_abs, bn_abs, bd_abs;
    logic        an_neg, bn_neg, zero_den, bad_kind;
    kind_t       k_in;

    kind_t       kind_reg;
    logic        early_reg;
    status_t     early_st_reg;
    logic [31:0] an_mag_reg, ad_mag_reg, bn_mag_reg, bd_mag_reg;
    logic        an_neg_reg, bn_neg_reg;
    logic [63:0] p_mag_reg [3];
    logic        p_neg_reg [3];
    logic [65:0] sum_reg;
    logic [63:0] s_mag_reg, t_mag_reg;
    logic        s_neg_reg;
    logic [63:0] x_reg, y_reg, g_reg;
    logic [5:0]  k_reg;
    logic [63:0] quo_reg, rem_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] qn_reg, qd_reg;
    logic [OUT_BITS-1:0] out_reg;

    always_comb begin
        an_w     = in_data[31:0];
        ad_w     = in_data[63:32];
        bn_w     = in_data[95:64];
        bd_w     = in_data[127:96];
        an_abs   = abs32(an_w);
        ad_abs   = abs32(ad_w);
        bn_abs   = abs32(bn_w);
        bd_abs   = abs32(bd_w);
        an_neg   = (an_w[31] ^ ad_w[31]) && (an_w != 32'd0);
        bn_neg   = (bn_w[31] ^ bd_w[31]) && (bn_w != 32'd0);
        k_in     = kind_t'(in_kind);
        bad_kind = in_kind > KIND_GT;
        zero_den = (ad_abs == 32'd0) || ((k_in != KIND_MAKE) && (bd_abs == 32'd0))
                || ((k_in == KIND_DIV) && (bn_abs == 32'd0));
    end

    // multiplier operand selection
    logic [31:0] mul_a, mul_b;
    logic        mul_neg;
    logic [63:0] prod;

    always_comb begin
        mul_a   = an_mag_reg;
        mul_b   = bd_mag_reg;
        mul_neg = an_neg_reg;
        case (cmd.idx)
            2'd0: begin
                mul_a = an_mag_reg;
                if (kind_reg == KIND_MUL) begin
                    mul_b   = bn_mag_reg;
                    mul_neg = an_neg_reg ^ bn_neg_reg;
                end else begin
                    mul_b   = bd_mag_reg;
                    mul_neg = an_neg_reg;
                end
            end
            2'd1: begin
                mul_a   = bn_mag_reg;
                mul_b   = ad_mag_reg;
                mul_neg = bn_neg_reg;
            end
            default: begin
                mul_a = ad_mag_reg;
                if (kind_reg == KIND_DIV) begin
                    mul_b   = bn_mag_reg;
                    mul_neg = bn_neg_reg;
                end else begin
                    mul_b   = bd_mag_reg;
                    mul_neg = 1'b0;
                end
            end
        endcase
        prod = mul_a * mul_b;
    end

    logic [65:0] v0, v1, sum_next, s_abs;

    always_comb begin
        v0 = to_signed(p_neg_reg[0], p_mag_reg[0]);
        v1 = to_signed(p_neg_reg[1], p_mag_reg[1]);
        case (kind_reg) inside
            KIND_MUL, KIND_DIV:  sum_next = v0;
            KIND_MAKE, KIND_ADD: sum_next = v0 + v1;
            default:             sum_next = v0 - v1;
        endcase
        s_abs = sum_reg[65] ? (~sum_reg + 66'd1) : sum_reg;
    end

    logic [64:0] rem_sh;
    logic        div_ge;
    logic [63:0] quo_next;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[63]};
        div_ge   = rem_sh >= {1'b0, g_reg};
        quo_next = {quo_reg[62:0], div_ge};
    end

    logic        ovf, d_zero, d_neg, cmp_bit;
    logic [63:0] num_val;
    logic [OUT_BITS-1:0] out_next;

    always_comb begin
        d_zero = sum_reg == 66'd0;
        d_neg  = sum_reg[65];
        case (kind_reg)
            KIND_EQ: cmp_bit = d_zero;
            KIND_NE: cmp_bit = !d_zero;
            KIND_LE: cmp_bit = d_neg || d_zero;
            KIND_GE: cmp_bit = !d_neg;
            KIND_LT: cmp_bit = d_neg;
            KIND_GT: cmp_bit = !d_neg && !d_zero;
            default: cmp_bit = 1'b0;
        endcase
        ovf = (s_neg_reg ? ({1'b0, qn_reg} > LIM) : ({1'b0, qn_reg} > LIM - 65'd1))
           || ({1'b0, qd_reg} > LIM - 65'd1) || (qd_reg == 64'd0);
        num_val = s_neg_reg ? (~qn_reg + 64'd1) : qn_reg;
        out_next = '0;
        if (early_reg) begin
            out_next[65:64] = early_st_reg;
        end else if (sts.is_cmp) begin
            out_next[63] = cmp_bit;
        end else if (ovf) begin
            out_next[65:64] = STS_OVERFLOW;
        end else begin
            out_next[31:0]  = num_val[31:0];
            out_next[62:32] = qd_reg[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                kind_reg     <= k_in;
                early_reg    <= bad_kind || zero_den;
                early_st_reg <= (!bad_kind && zero_den) ? STS_ZERO_DEN : STS_OK;
                an_mag_reg   <= an_abs;
                an_neg_reg   <= an_neg;
                ad_mag_reg   <= ad_abs;
                if (k_in == KIND_MAKE) begin
                    bn_mag_reg <= 32'd0;
                    bn_neg_reg <= 1'b0;
                    bd_mag_reg <= 32'd1;
                end else begin
                    bn_mag_reg <= bn_abs;
                    bn_neg_reg <= bn_neg;
                    bd_mag_reg <= bd_abs;
                end
            end
            OP_MUL: begin
                p_mag_reg[cmd.idx] <= prod;
                p_neg_reg[cmd.idx] <= mul_neg && (prod != 64'd0);
            end
            OP_COMBINE: sum_reg <= sum_next;
            OP_PREP: begin
                s_mag_reg <= s_abs[63:0];
                s_neg_reg <= sum_reg[65] ^ p_neg_reg[2];
                t_mag_reg <= p_mag_reg[2];
                x_reg     <= s_abs[63:0];
                y_reg     <= p_mag_reg[2];
                k_reg     <= 6'd0;
            end
            OP_GCD_STEP: begin
                if (!x_reg[0] && !y_reg[0]) begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + 6'd1;
                end else if (!x_reg[0]) begin
                    x_reg <= x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_reg <= y_reg >> 1;
                end else if (x_reg >= y_reg) begin
                    x_reg <= x_reg - y_reg;
                end else begin
                    y_reg <= y_reg - x_reg;
                end
            end
            OP_SCALE: g_reg <= y_reg << k_reg;
            OP_DIV_LOAD: begin
                quo_reg <= cmd.sel ? t_mag_reg : s_mag_reg;
                rem_reg <= 64'd0;
                cnt_reg <= 6'd0;
            end
            OP_DIV_STEP: begin
                rem_reg <= div_ge ? 64'(rem_sh - {1'b0, g_reg}) : rem_sh[63:0];
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    if (cmd.sel) begin
                        qd_reg <= quo_next;
                    end else begin
                        qn_reg <= quo_next;
                    end
                end
            end
            OP_WRITE: out_reg <= out_next;
            default: ;
        endcase
    end

    always_comb begin
        sts.early    = early_reg;
        sts.is_cmp   = (kind_reg >= KIND_EQ) && (kind_reg <= KIND_GT);
        sts.gcd_done = x_reg == 64'd0;
        sts.div_last = cnt_reg == 6'd63;
    end

    assign out_data = out_reg;

endmodule

[hw/rtl/rau_controller.sv]
`include "rational_arithmetic_unit_defines.svh"
module rau_controller
    import rau_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '{op: OP_NONE, idx: 2'd0, sel: 1'b0};
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:  state_next = sts.early ? ST_WRITE : ST_MUL0;
            ST_MUL0: begin
                cmd.op     = OP_MUL;
                cmd.idx    = 2'd0;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.op     = OP_MUL;
                cmd.idx    = 2'd1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.op     = OP_MUL;
                cmd.idx    = 2'd2;
                state_next = ST_COMBINE;
            end
            ST_COMBINE: begin
                cmd.op     = OP_COMBINE;
                state_next = sts.is_cmp ? ST_WRITE : ST_PREP;
            end
            ST_PREP: begin
                cmd.op     = OP_PREP;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                if (sts.gcd_done) begin
                    state_next = ST_SCALE;
                end else begin
                    cmd.op = OP_GCD_STEP;
                end
            end
            ST_SCALE: begin
                cmd.op     = OP_SCALE;
                state_next = ST_DIVLD_N;
            end
            ST_DIVLD_N: begin
                cmd.op     = OP_DIV_LOAD;
                state_next = ST_DIV_N;
            end
            ST_DIV_N: begin
                cmd.op = OP_DIV_STEP;
                if (sts.div_last) begin
                    state_next = ST_DIVLD_D;
                end
            end
            ST_DIVLD_D: begin
                cmd.op     = OP_DIV_LOAD;
                cmd.sel    = 1'b1;
                state_next = ST_DIV_D;
            end
            ST_DIV_D: begin
                cmd.op  = OP_DIV_STEP;
                cmd.sel = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.op        = OP_WRITE;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_tvalid_reg;

    `RAU_ASSERT_NXT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_DECODE)
    `RAU_ASSERT_NXT(a_early_skips, aclk, aresetn, state_reg == ST_DECODE && sts.early, state_reg == ST_WRITE)
    `RAU_ASSERT_NXT(a_gcd_exit, aclk, aresetn, state_reg == ST_GCD && sts.gcd_done, state_reg == ST_SCALE)
    `RAU_ASSERT_NXT(a_write_valid, aclk, aresetn, state_reg == ST_WRITE && !m_tvalid_reg, m_tvalid_reg && state_reg == ST_IDLE)

endmodule

[hw/rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit.
// Input channel s_*: one request per item; s_tuser carries the operation kind,
// s_tdata the two fractions. Output channel m_*: one result per request.
// Kinds: make, add, sub, mul, div and six comparisons of a against b.
// Flow per request: three 32x32 products on one multiplier, a 66-bit
// combine, a binary gcd (one shift or subtract a cycle), then numerator
// and denominator divided by the gcd on one restoring divider, one after the other.
// Fraction results take longer the more gcd steps they need; comparisons
// skip the gcd and the divider, and bad kinds and zero denominators go
// straight from decode to the write stage.
// One request in flight at a time.
// s_tready is high only while the unit is idle; a finished result sits in
// the output register and the next request is taken while it waits.
// If m_tready stays low, a second result waits in the write stage and the
// unit takes nothing more until the first is taken.
// Reset (aresetn low, synchronous) drops any request in flight and clears
// m_tvalid.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_BITS-1:0]  s_tdata,   // a_num, a_den, b_num, b_den
    input  logic [3:0]          s_tuser,   // kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_BITS-1:0] m_tdata    // res_num, res_den, cmp_true, status, zero pad
);

    cmd_t cmd;
    sts_t sts;

    rau_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rau_datapath u_dp (
        .aclk     (aclk),
        .cmd      (cmd),
        .in_kind  (s_tuser),
        .in_data  (s_tdata),
        .sts      (sts),
        .out_data (m_tdata)
    );

endmodule
